// ----- design/fps_pkg.sv -----
// Shared types and constants for the FCFS process scheduler.
// No dependencies; used by fps_scan and fcfs_process_scheduler_top.
`default_nettype none

package fps_pkg;

    localparam int DATA_W    = 16;   // arrival and burst fields
    localparam int TIME_W    = 32;   // wrapping time counter
    localparam int IDX_OUT_W = 4;    // index fields on the result ports

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Per-cycle control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;       // drop results of the previous scan
        logic eval;        // read data of one entry is valid this cycle
        logic need_pick;   // processor is free, look for a ready entry
    } scan_ctrl_t;

endpackage

`default_nettype wire

// ----- design/fps_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module fps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/fps_scan.sv -----
// Scan unit: walks table read data one entry per cycle and keeps the
// lowest arrival match and the lowest ready entry. Depends on fps_pkg.
`default_nettype none

module fps_scan #(
    parameter int IDX_W = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire fps_pkg::scan_ctrl_t        ctrl,
    input  wire logic [IDX_W-1:0]           idx,
    input  wire logic [fps_pkg::DATA_W-1:0] arrival,
    input  wire logic                       finished,
    input  wire logic [fps_pkg::TIME_W-1:0] now,
    output logic                            arr_found,
    output logic      [IDX_W-1:0]           arr_idx,
    output logic                            pick_found,
    output logic      [IDX_W-1:0]           pick_idx
);

    logic [fps_pkg::TIME_W-1:0] arrival_ext;
    logic                       arr_hit;
    logic                       pick_hit;

    assign arrival_ext = fps_pkg::TIME_W'(arrival);
    assign arr_hit     = !arr_found && (arrival_ext == now);
    assign pick_hit    = ctrl.need_pick && !pick_found && !finished && (arrival_ext <= now);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_found  <= 1'b0;
            pick_found <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            arr_found  <= 1'b0;
            pick_found <= 1'b0;
        end
        else if (ctrl.eval)
        begin
            if (arr_hit)
            begin
                arr_found <= 1'b1;
            end
            if (pick_hit)
            begin
                pick_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.eval && arr_hit)
        begin
            arr_idx <= idx;
        end
        if (ctrl.eval && pick_hit)
        begin
            pick_idx <= idx;
        end
    end

endmodule

`default_nettype wire

// ----- design/fcfs_process_scheduler_top.sv -----
// Top level of the FCFS process scheduler: sequencer, entry table RAM,
// finished flags and scan unit. Depends on fps_pkg, fps_ram, fps_scan.
//
//  channel   handshake                 payload
//  -------   ------------------------  ------------------------------------
//  command   start / busy              kind, arrival_time, burst_length
//  result    done (one-cycle strobe)   load_rejected, timestep, ticked_*,
//                                      remaining_after, arrived_*,
//                                      completed_*, running_*, all_done
//
// A beat is taken when start is high and busy is low; done marks its result
// for one cycle, starting as busy drops, and a new beat can be taken then.
// A load passes S_FINISH only; a tick passes S_SERVE if an entry is running,
// then S_SCAN (one entry read per cycle over all entries), then S_FINISH.
// Reset clears the control state; the table RAM needs no clearing.
// The receiver cannot stall: done is never held off.
`default_nettype none

module fcfs_process_scheduler_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [15:0] arrival_time,
    input  wire logic [15:0] burst_length,
    output logic             done,
    output logic             load_rejected,
    output logic      [31:0] timestep,
    output logic             ticked_valid,
    output logic      [3:0]  ticked_index,
    output logic      [15:0] remaining_after,
    output logic             arrived_valid,
    output logic      [3:0]  arrived_index,
    output logic             completed_valid,
    output logic      [3:0]  completed_index,
    output logic             running_valid,
    output logic      [3:0]  running_index,
    output logic             all_done
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W  = fps_pkg::DATA_W;
    localparam int TIME_W  = fps_pkg::TIME_W;
    localparam int OUT_W   = fps_pkg::IDX_OUT_W;
    localparam int WORD_W  = 2 * DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SERVE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     fin_cnt_reg;
    logic [MAX_ENTRIES-1:0] fin_flags_reg;
    logic [TIME_W-1:0]    time_reg;
    logic                 run_flag_reg;
    logic [IDX_W-1:0]     run_slot_reg;
    logic                 kind_reg;
    logic [CNT_W-1:0]     scan_addr_reg;
    logic                 pend_valid_reg;
    logic [IDX_W-1:0]     pend_idx_reg;

    logic                 done_reg;
    logic                 load_rejected_reg;
    logic [TIME_W-1:0]    timestep_reg;
    logic                 ticked_valid_reg;
    logic [OUT_W-1:0]     ticked_index_reg;
    logic [DATA_W-1:0]    remaining_after_reg;
    logic                 arrived_valid_reg;
    logic [OUT_W-1:0]     arrived_index_reg;
    logic                 completed_valid_reg;
    logic [OUT_W-1:0]     completed_index_reg;
    logic                 running_valid_reg;
    logic [OUT_W-1:0]     running_index_reg;
    logic                 all_done_reg;

    logic                 accept;
    logic                 table_full;
    logic                 scan_issue;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;
    logic [DATA_W-1:0]    rd_arrival;
    logic [DATA_W-1:0]    rd_remaining;
    logic [DATA_W-1:0]    rem_dec;

    fps_pkg::scan_ctrl_t  scan_ctrl;
    logic                 arr_found;
    logic [IDX_W-1:0]     arr_idx;
    logic                 pick_found;
    logic [IDX_W-1:0]     pick_idx;

    logic                 run_flag_next;
    logic [IDX_W-1:0]     run_slot_next;

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign scan_issue = (state_reg == S_SCAN) && (scan_addr_reg != count_reg);

    assign rd_arrival   = ram_rdata[WORD_W-1:DATA_W];
    assign rd_remaining = ram_rdata[DATA_W-1:0];
    assign rem_dec      = (rd_remaining == '0) ? '0 : rd_remaining - DATA_W'(1);

    // one write port: load appends, serve writes back the decremented entry
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = run_slot_reg;
        ram_wdata = {rd_arrival, rem_dec};
        if (accept && (kind == fps_pkg::KIND_LOAD) && !table_full)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = {arrival_time, burst_length};
        end
        else if (state_reg == S_SERVE)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re    = (accept && (kind == fps_pkg::KIND_TICK) && run_flag_reg) || scan_issue;
    assign ram_raddr = (state_reg == S_IDLE) ? run_slot_reg : scan_addr_reg[IDX_W-1:0];

    fps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_ctrl.clear     = accept;
    assign scan_ctrl.eval      = (state_reg == S_SCAN) && pend_valid_reg;
    assign scan_ctrl.need_pick = !run_flag_reg;

    fps_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .idx        (pend_idx_reg),
        .arrival    (rd_arrival),
        .finished   (fin_flags_reg[pend_idx_reg]),
        .now        (time_reg),
        .arr_found  (arr_found),
        .arr_idx    (arr_idx),
        .pick_found (pick_found),
        .pick_idx   (pick_idx)
    );

    // processor state as it stands after the close-out of this beat
    always_comb
    begin
        run_flag_next = run_flag_reg;
        run_slot_next = run_slot_reg;
        if ((kind_reg == fps_pkg::KIND_TICK) && !run_flag_reg && pick_found)
        begin
            run_flag_next = 1'b1;
            run_slot_next = pick_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            count_reg           <= '0;
            fin_cnt_reg         <= '0;
            fin_flags_reg       <= '0;
            time_reg            <= '0;
            run_flag_reg        <= 1'b0;
            run_slot_reg        <= '0;
            kind_reg            <= fps_pkg::KIND_LOAD;
            scan_addr_reg       <= '0;
            pend_valid_reg      <= 1'b0;
            pend_idx_reg        <= '0;
            done_reg            <= 1'b0;
            load_rejected_reg   <= 1'b0;
            timestep_reg        <= '0;
            ticked_valid_reg    <= 1'b0;
            ticked_index_reg    <= '0;
            remaining_after_reg <= '0;
            arrived_valid_reg   <= 1'b0;
            arrived_index_reg   <= '0;
            completed_valid_reg <= 1'b0;
            completed_index_reg <= '0;
            running_valid_reg   <= 1'b0;
            running_index_reg   <= '0;
            all_done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg            <= kind;
                        scan_addr_reg       <= '0;
                        pend_valid_reg      <= 1'b0;
                        load_rejected_reg   <= 1'b0;
                        ticked_valid_reg    <= 1'b0;
                        ticked_index_reg    <= '0;
                        remaining_after_reg <= '0;
                        completed_valid_reg <= 1'b0;
                        completed_index_reg <= '0;
                        if (kind == fps_pkg::KIND_LOAD)
                        begin
                            if (table_full)
                            begin
                                load_rejected_reg <= 1'b1;
                            end
                            else
                            begin
                                fin_flags_reg[count_reg[IDX_W-1:0]] <= 1'b0;
                                count_reg <= count_reg + CNT_W'(1);
                            end
                            state_reg <= S_FINISH;
                        end
                        else if (run_flag_reg)
                        begin
                            state_reg <= S_SERVE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SERVE:
                begin
                    ticked_valid_reg    <= 1'b1;
                    ticked_index_reg    <= OUT_W'(run_slot_reg);
                    remaining_after_reg <= rem_dec;
                    if (rem_dec == '0)
                    begin
                        fin_flags_reg[run_slot_reg] <= 1'b1;
                        fin_cnt_reg         <= fin_cnt_reg + CNT_W'(1);
                        completed_valid_reg <= 1'b1;
                        completed_index_reg <= OUT_W'(run_slot_reg);
                        run_flag_reg        <= 1'b0;
                        run_slot_reg        <= '0;
                    end
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    // read data of an issued entry comes back in the next cycle, with pend_valid and pend_idx
                    pend_valid_reg <= scan_issue;
                    pend_idx_reg   <= scan_addr_reg[IDX_W-1:0];
                    if (scan_issue)
                    begin
                        scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    done_reg          <= 1'b1;
                    timestep_reg      <= time_reg;
                    arrived_valid_reg <= arr_found;
                    arrived_index_reg <= arr_found ? OUT_W'(arr_idx) : '0;
                    running_valid_reg <= run_flag_next;
                    running_index_reg <= run_flag_next ? OUT_W'(run_slot_next) : '0;
                    all_done_reg      <= (fin_cnt_reg == count_reg);
                    run_flag_reg      <= run_flag_next;
                    run_slot_reg      <= run_slot_next;
                    if (kind_reg == fps_pkg::KIND_TICK)
                    begin
                        time_reg <= time_reg + TIME_W'(1);
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done            = done_reg;
    assign load_rejected   = load_rejected_reg;
    assign timestep        = timestep_reg;
    assign ticked_valid    = ticked_valid_reg;
    assign ticked_index    = ticked_index_reg;
    assign remaining_after = remaining_after_reg;
    assign arrived_valid   = arrived_valid_reg;
    assign arrived_index   = arrived_index_reg;
    assign completed_valid = completed_valid_reg;
    assign completed_index = completed_index_reg;
    assign running_valid   = running_valid_reg;
    assign running_index   = running_index_reg;
    assign all_done        = all_done_reg;

    // a result beat only follows the close-out state
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FINISH))
        else $error("done without close-out");

    a_fin_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fin_cnt_reg <= count_reg)
        else $error("finished count exceeds entry count");

    // the running entry is always a loaded, unfinished entry
    a_running_live: assert property (@(posedge clk) disable iff (!rst_n)
        run_flag_reg |-> (CNT_W'(run_slot_reg) < count_reg) && !fin_flags_reg[run_slot_reg])
        else $error("running entry not live");

    a_completed_served: assert property (@(posedge clk) disable iff (!rst_n)
        (done && completed_valid) |->
            (ticked_valid && (remaining_after == '0) && (completed_index == ticked_index)))
        else $error("completion without served entry at zero");

endmodule

`default_nettype wire

// ----- verif/fcfs_sched_checker.sv -----
// Scoreboard for the FCFS process scheduler: watches the command and result
// ports, predicts one result per command beat and compares it field by field.
// Depends on fps_pkg.
`default_nettype none

module fcfs_sched_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          kind,
    input  wire logic [fps_pkg::DATA_W-1:0]    arrival_time,
    input  wire logic [fps_pkg::DATA_W-1:0]    burst_length,
    input  wire logic                          done,
    input  wire logic                          load_rejected,
    input  wire logic [fps_pkg::TIME_W-1:0]    timestep,
    input  wire logic                          ticked_valid,
    input  wire logic [fps_pkg::IDX_OUT_W-1:0] ticked_index,
    input  wire logic [fps_pkg::DATA_W-1:0]    remaining_after,
    input  wire logic                          arrived_valid,
    input  wire logic [fps_pkg::IDX_OUT_W-1:0] arrived_index,
    input  wire logic                          completed_valid,
    input  wire logic [fps_pkg::IDX_OUT_W-1:0] completed_index,
    input  wire logic                          running_valid,
    input  wire logic [fps_pkg::IDX_OUT_W-1:0] running_index,
    input  wire logic                          all_done,
    output int                                 fail_count,
    output int                                 in_flight,
    output int                                 checked
);

    localparam int SLOTS     = 16;
    localparam int DATA_W    = fps_pkg::DATA_W;
    localparam int TIME_W    = fps_pkg::TIME_W;
    localparam int IDX_OUT_W = fps_pkg::IDX_OUT_W;

    typedef struct packed {
        logic                 load_rejected;
        logic [TIME_W-1:0]    timestep;
        logic                 ticked_valid;
        logic [IDX_OUT_W-1:0] ticked_index;
        logic [DATA_W-1:0]    remaining_after;
        logic                 arrived_valid;
        logic [IDX_OUT_W-1:0] arrived_index;
        logic                 completed_valid;
        logic [IDX_OUT_W-1:0] completed_index;
        logic                 running_valid;
        logic [IDX_OUT_W-1:0] running_index;
        logic                 all_done;
    } sched_result_t;

    // Shadow of the process table and the processor
    logic [DATA_W-1:0]    arrival_slots [SLOTS];
    logic [DATA_W-1:0]    service_left  [SLOTS];
    logic                 finished      [SLOTS];
    int                   entry_total;
    logic [TIME_W-1:0]    sched_time;
    logic                 cpu_owned;
    logic [IDX_OUT_W-1:0] cpu_slot;

    sched_result_t pending_results [$];
    sched_result_t want;

    function automatic sched_result_t advance_schedule(input logic cmd_kind,
                                                       input logic [DATA_W-1:0] arr,
                                                       input logic [DATA_W-1:0] burst);
        sched_result_t r;
        logic          hit;
        int            i;
        r = '0;
        r.timestep = sched_time;
        if (cmd_kind == fps_pkg::KIND_LOAD)
        begin
            if (entry_total >= SLOTS)
                r.load_rejected = 1'b1;
            else
            begin
                arrival_slots[entry_total] = arr;
                service_left[entry_total]  = burst;
                finished[entry_total]      = 1'b0;
                entry_total++;
            end
        end
        else
        begin
            if (cpu_owned)
            begin
                // saturates, so a zero burst retires one tick after pick
                if (service_left[cpu_slot] != '0)
                    service_left[cpu_slot] = service_left[cpu_slot] - 1'b1;
                r.ticked_valid    = 1'b1;
                r.ticked_index    = cpu_slot;
                r.remaining_after = service_left[cpu_slot];
            end
            hit = 1'b0;
            for (i = 0; i < entry_total && !hit; i++)
            begin
                if ({16'h0, arrival_slots[i]} == sched_time)
                begin
                    hit             = 1'b1;
                    r.arrived_valid = 1'b1;
                    r.arrived_index = 4'(i);
                end
            end
            if (cpu_owned && service_left[cpu_slot] == '0)
            begin
                finished[cpu_slot] = 1'b1;
                r.completed_valid  = 1'b1;
                r.completed_index  = cpu_slot;
                cpu_owned          = 1'b0;
                cpu_slot           = '0;
            end
            // non-preemptive: only look for work when the processor is free
            for (i = 0; i < entry_total && !cpu_owned; i++)
            begin
                if (!finished[i] && {16'h0, arrival_slots[i]} <= sched_time)
                begin
                    cpu_owned = 1'b1;
                    cpu_slot  = 4'(i);
                end
            end
            sched_time = sched_time + 1'b1;
        end
        r.running_valid = cpu_owned;
        r.running_index = cpu_owned ? cpu_slot : '0;
        r.all_done      = 1'b1;
        for (i = 0; i < entry_total; i++)
        begin
            if (!finished[i])
                r.all_done = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string field_name, input logic [31:0] expected_v,
                               input logic [31:0] actual_v);
        if (expected_v !== actual_v)
        begin
            $display("%0t  %s: expected %0h, actual %0h", $time, field_name,
                     expected_v, actual_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total = 0;
            sched_time  = '0;
            cpu_owned   = 1'b0;
            cpu_slot    = '0;
            foreach (finished[j])
                finished[j] = 1'b0;
            pending_results.delete();
            fail_count = 0;
            checked    = 0;
            in_flight <= 0;
        end
        else
        begin
            // result first: a new beat can be taken in the same cycle as done
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t  result beat with no command outstanding", $time);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("load_rejected", want.load_rejected, load_rejected);
                    check_field("timestep", want.timestep, timestep);
                    check_field("ticked_valid", want.ticked_valid, ticked_valid);
                    check_field("ticked_index", want.ticked_index, ticked_index);
                    check_field("remaining_after", want.remaining_after, remaining_after);
                    check_field("arrived_valid", want.arrived_valid, arrived_valid);
                    check_field("arrived_index", want.arrived_index, arrived_index);
                    check_field("completed_valid", want.completed_valid, completed_valid);
                    check_field("completed_index", want.completed_index, completed_index);
                    check_field("running_valid", want.running_valid, running_valid);
                    check_field("running_index", want.running_index, running_index);
                    check_field("all_done", want.all_done, all_done);
                    checked++;
                end
            end
            if (start && !busy)
                pending_results = {pending_results,
                                   advance_schedule(kind, arrival_time, burst_length)};
            in_flight <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench top for fcfs_process_scheduler_top: clock, reset, command stimulus
// and verdict. Depends on fps_pkg, the scheduler RTL and fcfs_sched_checker.
`default_nettype none

module testbench;

    localparam int TABLE_SLOTS    = 16;
    localparam int RANDOM_BEATS   = 1180;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 25;
    localparam int DATA_W         = fps_pkg::DATA_W;
    localparam int TIME_W         = fps_pkg::TIME_W;
    localparam int IDX_OUT_W      = fps_pkg::IDX_OUT_W;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 kind;
    logic [DATA_W-1:0]    arrival_time;
    logic [DATA_W-1:0]    burst_length;
    logic                 busy;
    logic                 done;
    logic                 load_rejected;
    logic [TIME_W-1:0]    timestep;
    logic                 ticked_valid;
    logic [IDX_OUT_W-1:0] ticked_index;
    logic [DATA_W-1:0]    remaining_after;
    logic                 arrived_valid;
    logic [IDX_OUT_W-1:0] arrived_index;
    logic                 completed_valid;
    logic [IDX_OUT_W-1:0] completed_index;
    logic                 running_valid;
    logic [IDX_OUT_W-1:0] running_index;
    logic                 all_done;

    int fail_count;
    int in_flight;
    int checked;

    int stall_cycles;
    int sender_idle_pct = 38;
    int sim_now         = 0;    // scheduler time as seen from accepted ticks
    int table_fill      = 0;
    int ticks_sent      = 0;
    int loads_sent      = 0;
    int loads_refused   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    fcfs_process_scheduler_top uut (.*);

    fcfs_sched_checker chk (.*);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        do
            @(posedge clk);
        while (stall_cycles < WATCHDOG_LIMIT);
        $display("%0t  watchdog: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic issue_beat(input logic k, input logic [DATA_W-1:0] arr,
                              input logic [DATA_W-1:0] bur);
        start        <= 1'b1;
        kind         <= k;
        arrival_time <= arr;
        burst_length <= bur;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (k == fps_pkg::KIND_TICK)
        begin
            ticks_sent++;
            sim_now++;
        end
        else
        begin
            loads_sent++;
            if (table_fill >= TABLE_SLOTS)
                loads_refused++;
            else
                table_fill++;
        end
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
    endtask

    initial
    begin
        int                n;
        logic [DATA_W-1:0] arr;
        logic [DATA_W-1:0] bur;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        kind         <= fps_pkg::KIND_TICK;
        arrival_time <= '0;
        burst_length <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, zero burst, arrival at the current time,
        // shared arrival (lowest index wins), late load of an arrived entry
        issue_beat(fps_pkg::KIND_TICK, '0, '0);
        issue_beat(fps_pkg::KIND_LOAD, 16'd0, 16'd0);
        issue_beat(fps_pkg::KIND_LOAD, 16'd1, 16'd3);
        repeat (2) issue_beat(fps_pkg::KIND_TICK, '0, '0);
        issue_beat(fps_pkg::KIND_LOAD, 16'd4, 16'd1);
        issue_beat(fps_pkg::KIND_LOAD, 16'd4, 16'd0);
        repeat (6) issue_beat(fps_pkg::KIND_TICK, '1, '1);
        issue_beat(fps_pkg::KIND_LOAD, 16'd2, 16'd2);
        repeat (4) issue_beat(fps_pkg::KIND_TICK, '0, '0);
        drain();

        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            sender_idle_pct = (n < RANDOM_BEATS / 3)     ? 38 :
                              (n < 2 * RANDOM_BEATS / 3) ? 55 : 0;
            if (table_fill < TABLE_SLOTS &&
                ($urandom_range(59, 0) == 0 || n >= RANDOM_BEATS - 100))
            begin
                if (table_fill == TABLE_SLOTS - 1)
                begin
                    // last slot takes the field extremes; it never arrives
                    arr = '1;
                    bur = '1;
                end
                else
                begin
                    case ($urandom_range(2, 0))
                        0:       arr = 16'($urandom_range(sim_now, 0));
                        1:       arr = 16'(sim_now);
                        default: arr = 16'(sim_now + $urandom_range(60, 1));
                    endcase
                    bur = ($urandom_range(7, 0) == 0) ? '0 : 16'($urandom_range(24, 1));
                end
                issue_beat(fps_pkg::KIND_LOAD, arr, bur);
            end
            else if (table_fill >= TABLE_SLOTS && $urandom_range(9, 0) == 0)
                issue_beat(fps_pkg::KIND_LOAD, 16'($urandom), 16'($urandom));
            else
                issue_beat(fps_pkg::KIND_TICK, 16'($urandom), 16'($urandom));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d ticks to time %0d and %0d loads, %0d of them refused on a full table;",
                 ticks_sent, sim_now, loads_sent, loads_refused);
        $display("%0d result beats compared, %0d field errors.", checked, fail_count);
        if (fail_count == 0 && in_flight == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
